### design/first_unique_letter_tracker_macros.svh
// Assertion macros for the first unique letter tracker.
`ifndef FIRST_UNIQUE_LETTER_TRACKER_MACROS_SVH
`define FIRST_UNIQUE_LETTER_TRACKER_MACROS_SVH

// Same-cycle implication, checked on aclk, disabled while aresetn is low.
`define FLUT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on aclk, disabled while aresetn is low.
`define FLUT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### design/flut_pkg.sv
// Shared types and constants of the first unique letter tracker.
package flut_pkg;

    localparam int LETTER_W = 5;
    localparam int TDATA_W  = 8;

    typedef logic [LETTER_W-1:0] letter_t;

    // One queue slot.
    typedef struct packed {
        logic    valid;
        letter_t code;
    } flut_entry_t;

    // Carried from a cell to the next one down the chain.
    typedef struct packed {
        logic prev_valid;  // upstream cell currently holds a letter
        logic shift;       // removal hit at or above this cell
        logic first;       // set only into the head cell
    } flut_link_t;

    // Broadcast to every cell; the flags are all zero when no transaction is taken.
    typedef struct packed {
        logic    clear;
        logic    append;
        logic    remove;
        letter_t letter;
    } flut_ctrl_t;

endpackage

### design/flut_cell.sv
// One queue cell: holds a letter, compares it, and moves up on a removal.
module flut_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  flut_pkg::flut_ctrl_t ctrl_i,
    input  flut_pkg::flut_link_t link_i,
    output flut_pkg::flut_link_t link_o,
    input  flut_pkg::flut_entry_t succ_i,
    output flut_pkg::flut_entry_t ent_o,
    output flut_pkg::flut_entry_t ent_next_o
);

    logic              valid_reg;
    logic              valid_next;
    flut_pkg::letter_t code_reg;
    flut_pkg::letter_t code_next;
    logic              match;
    logic              shift;
    logic              tail;

    always_comb begin
        match      = ctrl_i.remove & valid_reg & (code_reg == ctrl_i.letter);
        shift      = link_i.shift | match;
        // first empty slot after the occupied prefix
        tail       = ~valid_reg & link_i.prev_valid;
        valid_next = valid_reg;
        code_next  = code_reg;
        if (ctrl_i.clear) begin
            valid_next = ctrl_i.append & link_i.first;
            code_next  = ctrl_i.letter;
        end else if (shift) begin
            valid_next = succ_i.valid;
            code_next  = succ_i.code;
        end else if (ctrl_i.append & tail) begin
            valid_next = 1'b1;
            code_next  = ctrl_i.letter;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg <= code_next;
    end

    assign link_o     = '{prev_valid: valid_reg, shift: shift, first: 1'b0};
    assign ent_o      = '{valid: valid_reg, code: code_reg};
    assign ent_next_o = '{valid: valid_next, code: code_next};

endmodule

### design/first_unique_letter_tracker.sv
// First non-repeating letter of a stream, kept in a chain of queue cells.
// The result is registered into the output register, or the skid slot on a stall.
// Throughput: one transaction per cycle unless the skid slot is full; the path is
//   the removal compare rippling from the head down the ALPHABET_SIZE-cell chain.
// Reset (aresetn low, synchronous): empties the cells, seen bits and output
//   registers; no clearing pass, the block is ready right after reset.
module first_unique_letter_tracker #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [flut_pkg::TDATA_W-1:0] s_tdata,  // [4:0] letter, rest zero
    input  logic                         s_tuser,  // [0] new_stream
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [flut_pkg::TDATA_W-1:0] m_tdata,  // [4:0] first_unique, rest zero
    output logic                         m_tuser   // [0] found
);

    localparam int IDX_W  = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int LAST   = ALPHABET_SIZE - 1;
    localparam int ZPAD_W = flut_pkg::TDATA_W - flut_pkg::LETTER_W;

    logic                        accept;
    logic                        in_range;
    logic [IDX_W-1:0]            seen_idx;
    logic                        seen_hit;
    logic [ALPHABET_SIZE-1:0]    seen_mask_reg;
    logic [ALPHABET_SIZE-1:0]    seen_mask_next;
    logic [ALPHABET_SIZE-1:0]    valid_vec;
    flut_pkg::letter_t           letter;
    flut_pkg::flut_ctrl_t        ctrl;
    flut_pkg::flut_link_t        link_in  [ALPHABET_SIZE];
    flut_pkg::flut_link_t        link_out [ALPHABET_SIZE];
    flut_pkg::flut_entry_t       ent      [ALPHABET_SIZE];
    flut_pkg::flut_entry_t       ent_next [ALPHABET_SIZE];
    flut_pkg::flut_entry_t       succ     [ALPHABET_SIZE];

    logic                        res_found;
    flut_pkg::letter_t           res_code;
    logic                        out_valid_reg;
    logic                        out_found_reg;
    flut_pkg::letter_t           out_code_reg;
    logic                        skid_valid_reg;
    logic                        skid_found_reg;
    flut_pkg::letter_t           skid_code_reg;

    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;
    assign letter   = s_tdata[flut_pkg::LETTER_W-1:0];
    assign in_range = 32'(letter) < ALPHABET_SIZE;
    assign seen_idx = IDX_W'(letter);
    assign seen_hit = in_range & seen_mask_reg[seen_idx];

    always_comb begin
        ctrl.clear  = accept & s_tuser;
        ctrl.append = accept & in_range & (s_tuser | ~seen_hit);
        ctrl.remove = accept & in_range & ~s_tuser & seen_hit;
        ctrl.letter = letter;
    end

    always_comb begin
        seen_mask_next = ctrl.clear ? '0 : seen_mask_reg;
        if (ctrl.append) begin
            seen_mask_next[seen_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_mask_reg <= '0;
        end else begin
            seen_mask_reg <= seen_mask_next;
        end
    end

    // queue cells, head at index 0
    genvar gi;
    generate
        for (gi = 0; gi < ALPHABET_SIZE; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign link_in[gi] = '{prev_valid: 1'b1, shift: 1'b0, first: 1'b1};
            end else begin : g_body
                assign link_in[gi] = link_out[gi-1];
            end
            if (gi == LAST) begin : g_tail
                assign succ[gi] = '{valid: 1'b0, code: '0};
            end else begin : g_mid
                assign succ[gi] = ent[gi+1];
            end
            assign valid_vec[gi] = ent[gi].valid;

            flut_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl_i     (ctrl),
                .link_i     (link_in[gi]),
                .link_o     (link_out[gi]),
                .succ_i     (succ[gi]),
                .ent_o      (ent[gi]),
                .ent_next_o (ent_next[gi])
            );
        end
    endgenerate

    assign res_found = ent_next[0].valid;
    assign res_code  = res_found ? ent_next[0].code : '0;

    // output register with one skid slot behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg  <= skid_valid_reg | accept;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_found_reg <= skid_found_reg;
                out_code_reg  <= skid_code_reg;
            end else begin
                out_found_reg <= res_found;
                out_code_reg  <= res_code;
            end
        end else if (accept) begin
            skid_found_reg <= res_found;
            skid_code_reg  <= res_code;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {{ZPAD_W{1'b0}}, out_code_reg};

`include "first_unique_letter_tracker_macros.svh"

    `FLUT_ASSERT_NOW(a_queue_prefix, 1'b1, (valid_vec & (valid_vec + ALPHABET_SIZE'(1))) == '0, "queue cells not a contiguous prefix")
    `FLUT_ASSERT_NOW(a_queue_le_seen, 1'b1, $countones(valid_vec) <= $countones(seen_mask_reg), "more queued letters than seen letters")
    `FLUT_ASSERT_NOW(a_shift_needs_remove, link_out[LAST].shift, ctrl.remove, "chain shifted without a removal")
    `FLUT_ASSERT_NEXT(a_restart_single, accept && s_tuser && in_range, valid_vec[0] && $countones(seen_mask_reg) == 1, "new stream did not leave one letter")

endmodule
